@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mm_pkg.sv @@
package mm_pkg;

    localparam int MM_MAX_DIM = 8;
    localparam int DIM_W      = 4;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 35;

    typedef logic [1:0] t_op;
    localparam t_op OP_WR_A = 2'd0;
    localparam t_op OP_WR_B = 2'd1;
    localparam t_op OP_MUL  = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ROWS_A    = 2'd0;
    localparam t_reg_idx REG_INNER_DIM = 2'd1;
    localparam t_reg_idx REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

    // A dimension of zero acts as one; anything above the maximum saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] x;
        x = v;
        if (x == '0) begin
            x = DIM_W'(1);
        end
        if (x > max_dim) begin
            x = max_dim;
        end
        return x;
    endfunction

endpackage

@@ src/mm_ram.sv @@
module mm_ram
    import mm_pkg::*;
#(
    parameter int DEPTH = MM_MAX_DIM * MM_MAX_DIM,
    parameter int WIDTH = VAL_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mm_mac.sv @@
module mm_mac
    import mm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_done
);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_prod_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_ctl <= i_ctl;
            r_done     <= r_prod_ctl.vld && r_prod_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        if (r_prod_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    // The first term of a dot product restarts the sum.
    always_comb begin
        if (r_prod_ctl.first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

@@ src/matrix_multiply_core.sv @@
// Channel | Dir | Handshake                     | Payload
// ------- | --- | ----------------------------- | ---------------------------------------------
// input   | in  | i_in_valid / o_in_ready       | i_op, i_row, i_col, i_value
// output  | out | o_out_valid / i_out_ready     | o_out_row, o_out_col, o_out_value, o_out_last
// config  | in  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A load beat leaves the block idle, so it stays ready for the next beat.
// A compute beat walks the rows_a * cols_b result elements in turn: each result
// element reads one A and one B entry per cycle from the two stores,
// then waits for the read, multiply and accumulate stages to drain.
// Input is held off during a compute, and a stalled output holds the walk.
// Reset is synchronous and sets every dimension register to eight, clamped to MAX_DIM.

module matrix_multiply_core
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MM_MAX_DIM
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic [IDX_W-1:0]        i_row,
    input  logic [IDX_W-1:0]        i_col,
    input  logic signed [VAL_W-1:0] i_value,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [ACC_W-1:0] o_out_value,
    output logic                    o_out_last,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // Configuration registers.
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner;
    logic [DIM_W-1:0] r_cols_b;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= clamp_dim(DIM_W'(8), DIM_MAX);
            r_inner  <= clamp_dim(DIM_W'(8), DIM_MAX);
            r_cols_b <= clamp_dim(DIM_W'(8), DIM_MAX);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS_A:    r_rows_a <= clamp_dim(pwdata[DIM_W-1:0], DIM_MAX);
                REG_INNER_DIM: r_inner  <= clamp_dim(pwdata[DIM_W-1:0], DIM_MAX);
                REG_COLS_B:    r_cols_b <= clamp_dim(pwdata[DIM_W-1:0], DIM_MAX);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS_A:    prdata = 32'(r_rows_a);
            REG_INNER_DIM: prdata = 32'(r_inner);
            REG_COLS_B:    prdata = 32'(r_cols_b);
            default:       prdata = '0;
        endcase
    end

    // Loads.
    logic          in_acc;
    logic          in_range;
    logic          we_a;
    logic          we_b;
    logic [AW-1:0] waddr;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_range = ({1'b0, i_row} < DIM_MAX) && ({1'b0, i_col} < DIM_MAX);
    assign we_a     = in_acc && in_range && (i_op == OP_WR_A);
    assign we_b     = in_acc && in_range && (i_op == OP_WR_B);
    assign waddr    = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);

    // Walk over result elements and the inner index.
    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_r;
    logic [IW-1:0] n_r;
    logic [IW-1:0] r_c;
    logic [IW-1:0] n_c;
    logic [IW-1:0] r_k;
    logic [IW-1:0] n_k;
    t_mac_ctl      issue_ctl;
    t_mac_ctl      r_rd_ctl;
    logic          load_out;
    logic          out_free;
    logic          row_last;
    logic          col_last;
    logic          k_last;
    logic          mac_done;

    logic [AW-1:0]           raddr_a;
    logic [AW-1:0]           raddr_b;
    logic signed [VAL_W-1:0] rdata_a;
    logic signed [VAL_W-1:0] rdata_b;
    logic signed [ACC_W-1:0] mac_acc;

    assign raddr_a  = AW'(r_r) * AW'(MAX_DIM) + AW'(r_k);
    assign raddr_b  = AW'(r_k) * AW'(MAX_DIM) + AW'(r_c);
    assign row_last = (DIM_W'(r_r) + DIM_W'(1)) == r_rows_a;
    assign col_last = (DIM_W'(r_c) + DIM_W'(1)) == r_cols_b;
    assign k_last   = (DIM_W'(r_k) + DIM_W'(1)) == r_inner;
    assign out_free = !o_out_valid || i_out_ready;

    // Loads are only taken while idle, so a store write never meets a read of the
    // same entry.
    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_r      <= '0;
            r_c      <= '0;
            r_k      <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_r      <= n_r;
            r_c      <= n_c;
            r_k      <= n_k;
            r_rd_ctl <= issue_ctl;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_r       = r_r;
        n_c       = r_c;
        n_k       = r_k;
        issue_ctl = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_op == OP_MUL)) begin
                    n_r     = '0;
                    n_c     = '0;
                    n_k     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue_ctl.vld   = 1'b1;
                issue_ctl.first = (r_k == '0);
                issue_ctl.last  = k_last;
                if (k_last) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (row_last && col_last) begin
                        n_state = ST_IDLE;
                    end else if (col_last) begin
                        n_c     = '0;
                        n_r     = r_r + IW'(1);
                        n_state = ST_RUN;
                    end else begin
                        n_c     = r_c + IW'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W),
        .AW    (AW)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W),
        .AW    (AW)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // Output register.
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row;
    logic [IDX_W-1:0]        r_out_col;
    logic signed [ACC_W-1:0] r_out_value;
    logic                    r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row   <= IDX_W'(r_r);
            r_out_col   <= IDX_W'(r_c);
            r_out_value <= mac_acc;
            r_out_last  <= row_last && col_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

@@ src/mm_checker.sv @@
`include "assert_macros.svh"

module mm_checker
    import mm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [1:0]              i_op,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [IDX_W-1:0]        o_out_row,
    input logic [IDX_W-1:0]        o_out_col,
    input logic signed [ACC_W-1:0] o_out_value,
    input logic                    o_out_last
);

    logic                       r_valid_prev;
    logic                       out_stall;
    logic                       in_beat;
    logic                       mul_beat;
    logic                       load_idle;
    logic                       first_rise;
    logic [2*IDX_W+ACC_W:0]     out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_prev <= 1'b0;
        end else begin
            r_valid_prev <= o_out_valid;
        end
    end

    assign out_stall  = o_out_valid && !i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;
    assign mul_beat   = in_beat && (i_op == OP_MUL);
    assign load_idle  = in_beat && (i_op != OP_MUL) && !o_out_valid;
    assign first_rise = o_out_valid && !r_valid_prev && (o_out_row == '0) && (o_out_col == '0);
    assign out_beat   = {o_out_row, o_out_col, o_out_value, o_out_last};

    // A stalled result beat keeps its contents.
    `MM_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(out_beat), "result beat changed")

    // A compute beat holds off input in the following cycle.
    `MM_ASSERT_NEXT(a_mul_busy, mul_beat, !o_in_ready, "input taken right after a compute beat")

    // A load beat taken while no result is pending does not produce one.
    `MM_ASSERT_NEXT(a_load_quiet, load_idle, !o_out_valid, "result appeared after a load beat")

    // The first result of a product only appears while a compute is in progress or just finished.
    `MM_ASSERT_SAME(a_first_out, first_rise, !o_in_ready || o_out_last, "first result while idle")

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (.*);

@@ tb/tb_matrix_multiply_core.sv @@
module tb_matrix_multiply_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mm_pkg::*;

    localparam t_op         OP_NONE     = 2'd3;
    localparam int          TAIL_CYCLES = 16;
    localparam int          RAND_ITEMS  = 380;
    localparam logic [15:0] Q_MIN       = 16'h8000;
    localparam logic [15:0] Q_MAX       = 16'h7fff;

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } t_product_elem;

    // Mirrors the two element stores and the dimension registers, and keeps
    // the product elements that a multiply beat has yet to deliver.
    class product_tracker;
        logic signed [VAL_W-1:0] a_mem [MM_MAX_DIM*MM_MAX_DIM];
        logic signed [VAL_W-1:0] b_mem [MM_MAX_DIM*MM_MAX_DIM];
        int unsigned             rows;
        int unsigned             inner;
        int unsigned             cols;
        t_product_elem           pending [$];
        int                      errors;
        int                      checked;

        function new();
            rows    = MM_MAX_DIM;
            inner   = MM_MAX_DIM;
            cols    = MM_MAX_DIM;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_dim(t_reg_idx idx, logic [31:0] data);
            int unsigned v;
            v = int'(data[DIM_W-1:0]);
            if (v == 0) begin
                v = 1;
            end
            if (v > MM_MAX_DIM) begin
                v = MM_MAX_DIM;
            end
            case (idx)
                REG_ROWS_A:    rows  = v;
                REG_INNER_DIM: inner = v;
                REG_COLS_B:    cols  = v;
                default: ;
            endcase
        endfunction

        function void note_beat(t_op op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic signed [VAL_W-1:0] value);
            t_product_elem           e;
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] term;
            case (op)
                OP_WR_A: a_mem[int'(row)*MM_MAX_DIM + int'(col)] = value;
                OP_WR_B: b_mem[int'(row)*MM_MAX_DIM + int'(col)] = value;
                OP_MUL: begin
                    for (int r = 0; r < rows; r++) begin
                        for (int c = 0; c < cols; c++) begin
                            acc = '0;
                            for (int k = 0; k < inner; k++) begin
                                term = ACC_W'(a_mem[r*MM_MAX_DIM + k])
                                     * ACC_W'(b_mem[k*MM_MAX_DIM + c]);
                                acc  = acc + term;
                            end
                            e.row   = IDX_W'(r);
                            e.col   = IDX_W'(c);
                            e.value = acc;
                            e.last  = (r == rows - 1) && (c == cols - 1);
                            pending.push_back(e);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic signed [63:0] want,
                              logic signed [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                    logic signed [ACC_W-1:0] value, logic last);
            t_product_elem e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected product element, expected none,", $time);
                $display("    actual row %0d col %0d value %0d last %0b",
                         row, col, value, last);
                return;
            end
            e = pending.pop_front();
            compare("out_row", e.row, row);
            compare("out_col", e.col, col);
            compare("out_value", e.value, value);
            compare("out_last", e.last, last);
        endfunction

        function int pending_count();
            return pending.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_op                     i_op;
    logic [IDX_W-1:0]        i_row;
    logic [IDX_W-1:0]        i_col;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [IDX_W-1:0]        o_out_row;
    logic [IDX_W-1:0]        o_out_col;
    logic signed [ACC_W-1:0] o_out_value;
    logic                    o_out_last;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    product_tracker tracker = new();

    int sender_idle_pct = 0;
    int sink_idle_pct   = 0;
    int n_loads         = 0;
    int n_muls          = 0;
    int n_cfg           = 0;
    bit a_set [MM_MAX_DIM*MM_MAX_DIM];
    bit b_set [MM_MAX_DIM*MM_MAX_DIM];

    matrix_multiply_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_product(o_out_row, o_out_col, o_out_value, o_out_last);
        end
    end

    task automatic send_beat(t_op op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [VAL_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op       = op;
        i_row      = row;
        i_col      = col;
        i_value    = value;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_beat(op, row, col, value);
        case (op)
            OP_WR_A: begin
                a_set[int'(row)*MM_MAX_DIM + int'(col)] = 1'b1;
                n_loads++;
            end
            OP_WR_B: begin
                b_set[int'(row)*MM_MAX_DIM + int'(col)] = 1'b1;
                n_loads++;
            end
            OP_MUL: n_muls++;
            default: ;
        endcase
    endtask

    // Holds the input off until every product element is out, then lets the
    // pipeline run dry for the tail that its argument gives.
    task automatic settle(int tail);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_count() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_dim(t_reg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_dim(idx, data);
        n_cfg++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_dims(logic [31:0] r, logic [31:0] k, logic [31:0] c);
        settle(TAIL_CYCLES);
        write_dim(REG_ROWS_A, r);
        write_dim(REG_INNER_DIM, k);
        write_dim(REG_COLS_B, c);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small sizes; zero and values past the maximum check the clamping.
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd15;
            2: return MM_MAX_DIM;
            3: return $urandom;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // A few loads inside the active sizes, some noise, whatever entries the
    // multiply still needs, and then usually the multiply itself.
    task automatic run_sequence();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(9))
                0: send_beat(OP_NONE, IDX_W'($urandom), IDX_W'($urandom),
                             VAL_W'($urandom));
                1: send_beat($urandom_range(1) ? OP_WR_B : OP_WR_A, IDX_W'($urandom),
                             IDX_W'($urandom), pick_value());
                2, 3, 4, 5: send_beat(OP_WR_A, IDX_W'($urandom_range(tracker.rows - 1)),
                                      IDX_W'($urandom_range(tracker.inner - 1)),
                                      pick_value());
                default: send_beat(OP_WR_B, IDX_W'($urandom_range(tracker.inner - 1)),
                                   IDX_W'($urandom_range(tracker.cols - 1)), pick_value());
            endcase
        end
        for (int r = 0; r < tracker.rows; r++) begin
            for (int k = 0; k < tracker.inner; k++) begin
                if (!a_set[r*MM_MAX_DIM + k]) begin
                    send_beat(OP_WR_A, IDX_W'(r), IDX_W'(k), pick_value());
                end
            end
        end
        for (int k = 0; k < tracker.inner; k++) begin
            for (int c = 0; c < tracker.cols; c++) begin
                if (!b_set[k*MM_MAX_DIM + c]) begin
                    send_beat(OP_WR_B, IDX_W'(k), IDX_W'(c), pick_value());
                end
            end
        end
        if ($urandom_range(14) == 0) begin
            settle(0);
        end
        if ($urandom_range(9) != 0) begin
            send_beat(OP_MUL, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        end
    endtask

    initial begin
        int base;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = OP_WR_A;
        i_row      = '0;
        i_col      = '0;
        i_value    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extreme operands on a 2x2x2 product, an ignored op code and the
        // highest indexes.
        set_dims(2, 2, 2);
        send_beat(OP_WR_A, 0, 0, Q_MIN);
        send_beat(OP_WR_A, 0, 1, Q_MIN);
        send_beat(OP_WR_A, 1, 0, Q_MAX);
        send_beat(OP_WR_A, 1, 1, Q_MAX);
        send_beat(OP_WR_B, 0, 0, Q_MIN);
        send_beat(OP_WR_B, 1, 0, Q_MIN);
        send_beat(OP_WR_B, 0, 1, Q_MAX);
        send_beat(OP_WR_B, 1, 1, Q_MIN);
        send_beat(OP_NONE, 7, 7, 16'hffff);
        send_beat(OP_MUL, 0, 0, 16'h0000);
        send_beat(OP_WR_A, 7, 7, Q_MAX);
        send_beat(OP_WR_B, 7, 7, 16'h0000);

        // Zero rows acts as one and fifteen inner acts as the maximum; the
        // single element is the largest sum the block can produce.
        set_dims(0, 15, 1);
        for (int k = 2; k < MM_MAX_DIM; k++) begin
            send_beat(OP_WR_A, 0, IDX_W'(k), Q_MIN);
            send_beat(OP_WR_B, IDX_W'(k), 0, Q_MIN);
        end
        send_beat(OP_MUL, 7, 7, 16'hffff);

        base = n_loads + n_muls;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 22;
                    sink_idle_pct   = 83;
                end
                1: begin
                    sender_idle_pct = 83;
                    sink_idle_pct   = 22;
                end
                default: begin
                    sender_idle_pct = 0;
                    sink_idle_pct   = 0;
                end
            endcase
            if (phase == 0) begin
                set_dims(1, 1, 1);
                repeat (3) run_sequence();
            end
            while (n_loads + n_muls < base + RAND_ITEMS * (phase + 1) / 3) begin
                set_dims(pick_dim(), pick_dim(), pick_dim());
                repeat ($urandom_range(3, 8)) run_sequence();
            end
        end
        set_dims(MM_MAX_DIM, MM_MAX_DIM, MM_MAX_DIM);
        run_sequence();
        send_beat(OP_MUL, 0, 0, 16'h0000);
        settle(TAIL_CYCLES);

        $display("Ran %0d element loads and %0d products over %0d register writes,",
                 n_loads, n_muls, n_cfg);
        $display("sizes from 1 to %0d, with both sides stalling; %0d elements compared.",
                 MM_MAX_DIM, tracker.checked);
        if (tracker.errors == 0) begin
            $display("tb_matrix_multiply_core: PASS");
        end else begin
            $display("tb_matrix_multiply_core: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_matrix_multiply_core: FAIL");
        $finish;
    end

endmodule
